/* design/assert_macros.svh */
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/dpg_pkg.sv */
package dpg_pkg;

   localparam int unsigned CharW  = 8;
   localparam int unsigned WordW  = 32;
   localparam int unsigned UnitW  = 17;
   localparam int unsigned ProdW  = WordW + UnitW;
   localparam int unsigned ShiftW = 5;

   localparam logic [CharW-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CharW-1:0] CHAR_CR    = 8'd13;
   localparam logic [CharW-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CharW-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CharW-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CharW-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CharW-1:0] CHAR_UP_A  = 8'd65;
   localparam logic [CharW-1:0] CHAR_UP_Z  = 8'd90;
   localparam logic [CharW-1:0] CASE_GAP   = 8'd32;
   localparam logic [CharW-1:0] CHAR_LO_D  = 8'd100;
   localparam logic [CharW-1:0] CHAR_LO_H  = 8'd104;
   localparam logic [CharW-1:0] CHAR_LO_M  = 8'd109;
   localparam logic [CharW-1:0] CHAR_LO_S  = 8'd115;

   localparam logic [UnitW-1:0] UNIT_SEC  = 17'd1;
   localparam logic [UnitW-1:0] UNIT_MIN  = 17'(60);
   localparam logic [UnitW-1:0] UNIT_HOUR = 17'(60 * 60);
   localparam logic [UnitW-1:0] UNIT_DAY  = 17'(24 * 60 * 60);
   localparam logic [UnitW-1:0] UNIT_BAD  = 17'd0;

   localparam logic [WordW-1:0] DIGIT_LIMIT = 32'h7fff_ffff;
   localparam logic [WordW-1:0] DIGIT_HELD  = 32'h8000_0000;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_GCD,
      S_RESP
   } state_type;

   typedef enum logic {
      GCD_IDLE,
      GCD_RUN
   } gcd_state_type;

   typedef struct packed {
      phase_type        phase;
      logic             negative;
      logic [WordW-1:0] value;
      logic             overflow;
   } parse_type;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_space(input logic [CharW-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic [UnitW-1:0] unit_of(input logic [CharW-1:0] c);
      logic [CharW-1:0] lc;
      logic [UnitW-1:0] u;
      lc = c;
      if ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) begin
         lc = c + CASE_GAP;
      end
      if (is_digit(c)) begin
         u = UNIT_SEC;
      end else if (lc == CHAR_LO_S) begin
         u = UNIT_SEC;
      end else if (lc == CHAR_LO_M) begin
         u = UNIT_MIN;
      end else if (lc == CHAR_LO_H) begin
         u = UNIT_HOUR;
      end else if (lc == CHAR_LO_D) begin
         u = UNIT_DAY;
      end else begin
         u = UNIT_BAD;
      end
      return u;
   endfunction

endpackage

/* design/duration_parse_running_gcd_core.sv */
// Duration parser with running gcd. Characters of a duration string are taken one per
// cycle while req_stall is low; only the final character (req_is_last) produces a
// response, and no_char on a non-final transfer is ignored. After the final character
// the block stalls its input: the S_MUL state forms value times unit on a single 32x17
// multiplier, then a shared subtract/shift unit runs a binary gcd, one step per cycle,
// and the response waits in an output register until taken.
// An empty string skips both and responds on the next cycle; any other rejected string
// skips the gcd and responds after the multiply state. rsp_seconds is 0 for rejected
// strings; rsp_common_divisor always shows the running gcd of all accepted durations,
// 0 while none is nonzero.
module duration_parse_running_gcd_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dpg_pkg::CharW-1:0]  req_char_code,
   input  logic                       req_is_last,
   input  logic                       req_no_char,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_status,
   output logic [dpg_pkg::WordW-1:0]  rsp_seconds,
   output logic [dpg_pkg::WordW-1:0]  rsp_common_divisor
);

   dpg_pkg::state_type state_ff, state_in;
   dpg_pkg::parse_type parse_after;

   logic                       req_take;
   logic                       end_empty;
   logic                       end_char;
   logic                       negative_ff, overflow_ff;
   logic [dpg_pkg::WordW-1:0]  value_ff;
   logic [dpg_pkg::UnitW-1:0]  unit_ff;
   logic [dpg_pkg::ProdW-1:0]  product;
   logic                       mul_ok;
   logic                       status_ff;
   logic [dpg_pkg::WordW-1:0]  seconds_ff;
   logic [dpg_pkg::WordW-1:0]  gcd_ff, gcd_in;
   logic                       gcd_start, gcd_done;
   logic [dpg_pkg::WordW-1:0]  gcd_result;

   assign req_take  = req_valid && !req_stall;
   assign end_empty = req_take && req_is_last && req_no_char;
   assign end_char  = req_take && req_is_last && !req_no_char;

   dpg_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take_i      (req_take && !req_no_char),
      .clear_i     (req_take && req_is_last),
      .char_code_i (req_char_code),
      .after_o     (parse_after)
   );

   assign product = dpg_pkg::ProdW'(value_ff) * dpg_pkg::ProdW'(unit_ff);
   assign mul_ok  = (unit_ff != dpg_pkg::UNIT_BAD) && !overflow_ff
                 && !(negative_ff && value_ff != '0)
                 && (product[dpg_pkg::ProdW-1:dpg_pkg::WordW] == '0);

   dpg_gcd u_gcd (
      .clock    (clock),
      .reset    (reset),
      .start_i  (gcd_start),
      .a_i      (gcd_ff),
      .b_i      (product[dpg_pkg::WordW-1:0]),
      .done_o   (gcd_done),
      .result_o (gcd_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpg_pkg::S_IDLE: begin
            if (end_empty) begin
               state_in = dpg_pkg::S_RESP;
            end else if (end_char) begin
               state_in = dpg_pkg::S_MUL;
            end
         end
         dpg_pkg::S_MUL: state_in = mul_ok ? dpg_pkg::S_GCD : dpg_pkg::S_RESP;
         dpg_pkg::S_GCD: if (gcd_done) begin
            state_in = dpg_pkg::S_RESP;
         end
         dpg_pkg::S_RESP: if (!rsp_stall) begin
            state_in = dpg_pkg::S_IDLE;
         end
         default: state_in = dpg_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != dpg_pkg::S_IDLE);
      rsp_valid = (state_ff == dpg_pkg::S_RESP);
      gcd_start = (state_ff == dpg_pkg::S_MUL) && mul_ok;
   end

   assign gcd_in = gcd_done ? gcd_result : gcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpg_pkg::S_IDLE;
         gcd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         gcd_ff   <= gcd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_char) begin
         negative_ff <= parse_after.negative;
         overflow_ff <= parse_after.overflow;
         value_ff    <= parse_after.value;
         unit_ff     <= dpg_pkg::unit_of(req_char_code);
      end
      if (end_empty) begin
         status_ff  <= 1'b1;
         seconds_ff <= '0;
      end else if (state_ff == dpg_pkg::S_MUL) begin
         status_ff  <= !mul_ok;
         seconds_ff <= mul_ok ? product[dpg_pkg::WordW-1:0] : '0;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_seconds        = seconds_ff;
   assign rsp_common_divisor = gcd_ff;

endmodule

/* design/dpg_parser.sv */
module dpg_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take_i,
   input  logic                            clear_i,
   input  logic [dpg_pkg::CharW-1:0]       char_code_i,
   output dpg_pkg::parse_type              after_o
);

   dpg_pkg::parse_type parse_ff;
   dpg_pkg::parse_type parse_in;
   logic               digit;
   logic [dpg_pkg::WordW+3:0] acc;

   assign digit = dpg_pkg::is_digit(char_code_i);
   // value * 10 + digit, wide enough that it cannot wrap
   assign acc = {parse_ff.value, 3'b000} + {2'b00, parse_ff.value, 1'b0}
              + {(dpg_pkg::WordW)'(0), char_code_i[3:0] - dpg_pkg::CHAR_ZERO[3:0]};

   always_comb begin
      after_o = parse_ff;
      if (parse_ff.phase == dpg_pkg::PH_STOP) begin
         after_o = parse_ff;
      end else if (parse_ff.phase == dpg_pkg::PH_SPACE && !digit) begin
         if (dpg_pkg::is_space(char_code_i)) begin
            after_o = parse_ff;
         end else if (char_code_i == dpg_pkg::CHAR_PLUS ||
                      char_code_i == dpg_pkg::CHAR_MINUS) begin
            after_o.negative = (char_code_i == dpg_pkg::CHAR_MINUS);
            after_o.phase    = dpg_pkg::PH_SIGN;
         end else begin
            after_o.phase = dpg_pkg::PH_STOP;
         end
      end else if (!digit) begin
         after_o.phase = dpg_pkg::PH_STOP;
      end else begin
         after_o.phase = dpg_pkg::PH_DIGITS;
         if (acc > {4'b0000, dpg_pkg::DIGIT_LIMIT}) begin
            after_o.overflow = 1'b1;
            after_o.value    = dpg_pkg::DIGIT_HELD;
         end else begin
            after_o.value = acc[dpg_pkg::WordW-1:0];
         end
      end
   end

   always_comb begin
      parse_in = parse_ff;
      if (clear_i) begin
         parse_in = '{phase: dpg_pkg::PH_SPACE, negative: 1'b0,
                      value: '0, overflow: 1'b0};
      end else if (take_i) begin
         parse_in = after_o;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= '{phase: dpg_pkg::PH_SPACE, negative: 1'b0,
                       value: '0, overflow: 1'b0};
      end else begin
         parse_ff <= parse_in;
      end
   end

endmodule

/* design/dpg_gcd.sv */
module dpg_gcd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_i,
   input  logic [dpg_pkg::WordW-1:0]  a_i,
   input  logic [dpg_pkg::WordW-1:0]  b_i,
   output logic                       done_o,
   output logic [dpg_pkg::WordW-1:0]  result_o
);

   dpg_pkg::gcd_state_type state_ff, state_in;
   logic [dpg_pkg::WordW-1:0]  a_ff, a_in, b_ff, b_in;
   logic [dpg_pkg::ShiftW-1:0] k_ff, k_in;
   logic                       finish;
   logic                       a_gt_b;
   logic [dpg_pkg::WordW-1:0]  diff;

   assign finish = (a_ff == '0) || (b_ff == '0) || (a_ff == b_ff);
   assign a_gt_b = a_ff > b_ff;
   // one shared subtractor for the odd-odd step
   assign diff   = a_gt_b ? (a_ff - b_ff) : (b_ff - a_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpg_pkg::GCD_IDLE: if (start_i) begin
            state_in = dpg_pkg::GCD_RUN;
         end
         dpg_pkg::GCD_RUN: if (finish) begin
            state_in = dpg_pkg::GCD_IDLE;
         end
         default: state_in = dpg_pkg::GCD_IDLE;
      endcase
   end

   always_comb begin
      done_o = (state_ff == dpg_pkg::GCD_RUN) && finish;
      priority if (a_ff == '0) begin
         result_o = b_ff;
      end else if (b_ff == '0) begin
         result_o = a_ff;
      end else begin
         result_o = a_ff << k_ff;
      end
   end

   // binary gcd: one halving or one subtract-and-halve per cycle
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (start_i) begin
         a_in = a_i;
         b_in = b_i;
         k_in = '0;
      end else if (state_ff == dpg_pkg::GCD_RUN && !finish) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_gt_b) begin
            a_in = diff >> 1;
         end else begin
            b_in = diff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpg_pkg::GCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

endmodule

/* design/dpg_checker.sv */
`include "assert_macros.svh"

module dpg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_is_last,
   input logic                       req_no_char,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_status,
   input logic [dpg_pkg::WordW-1:0]  rsp_seconds,
   input logic [dpg_pkg::WordW-1:0]  rsp_common_divisor
);

   logic empty_end;

   assign empty_end = req_valid && !req_stall && req_is_last && req_no_char;

   // a rejected string never reports a duration
   `ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid && rsp_status, rsp_seconds == '0)
   // an accepted nonzero duration leaves a nonzero divisor
   `ASSERT_IMP(a_gcd_nonzero, clock, reset, rsp_valid && !rsp_status && rsp_seconds != '0,
      rsp_common_divisor != '0)
   // no character transfer while a response waits
   `ASSERT_IMP(a_hold_input, clock, reset, rsp_valid, req_stall)
   // an empty string is rejected on the next cycle
   `ASSERT_NXT(a_empty_reject, clock, reset, empty_end, rsp_valid && rsp_status)
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_seconds) && $stable(rsp_common_divisor))

endmodule

bind duration_parse_running_gcd_core dpg_checker u_dpg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_is_last        (req_is_last),
   .req_no_char        (req_no_char),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_seconds        (rsp_seconds),
   .rsp_common_divisor (rsp_common_divisor)
);

/* verif/duration_parse_running_gcd_core_test.sv */
module duration_parse_running_gcd_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;
   localparam int   TARGET_CHARS   = 1500;
   localparam int   IDLE_PERCENT   = 34;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   DRAIN_CYCLES   = 120;

   typedef struct packed {
      logic                      status;
      logic [dpg_pkg::WordW-1:0] seconds;
      logic [dpg_pkg::WordW-1:0] divisor;
   } duration_result_type;

   // predicts each string's response and matches the responses in order
   class gcd_scoreboard;
      dpg_pkg::phase_type        phase;
      logic                      negative;
      logic [dpg_pkg::WordW-1:0] value;
      logic                      overflow;
      logic [dpg_pkg::WordW-1:0] divisor;
      duration_result_type       expected_q[$];
      int                        errors;

      function new();
         clear_parse();
         divisor = '0;
         errors  = 0;
      endfunction

      function void clear_parse();
         phase    = dpg_pkg::PH_SPACE;
         negative = 1'b0;
         value    = '0;
         overflow = 1'b0;
      endfunction

      function void take_char(logic [dpg_pkg::CharW-1:0] c);
         logic        digit;
         logic [63:0] acc;
         digit = (c >= dpg_pkg::CHAR_ZERO) && (c <= dpg_pkg::CHAR_NINE);
         if (phase == dpg_pkg::PH_STOP) return;
         if (phase == dpg_pkg::PH_SPACE && !digit) begin
            if (c == dpg_pkg::CHAR_SPACE ||
                (c >= dpg_pkg::CHAR_TAB && c <= dpg_pkg::CHAR_CR)) return;
            if (c == dpg_pkg::CHAR_PLUS || c == dpg_pkg::CHAR_MINUS) begin
               negative = (c == dpg_pkg::CHAR_MINUS);
               phase    = dpg_pkg::PH_SIGN;
            end else begin
               phase = dpg_pkg::PH_STOP;
            end
            return;
         end
         if (!digit) begin
            phase = dpg_pkg::PH_STOP;
            return;
         end
         phase = dpg_pkg::PH_DIGITS;
         acc   = 64'(value) * 64'd10 + 64'(c - dpg_pkg::CHAR_ZERO);
         if (acc > 64'(dpg_pkg::DIGIT_LIMIT)) begin
            overflow = 1'b1;
            acc      = 64'(dpg_pkg::DIGIT_HELD);
         end
         value = acc[dpg_pkg::WordW-1:0];
      endfunction

      function logic [dpg_pkg::UnitW-1:0] scale_for(logic [dpg_pkg::CharW-1:0] c);
         logic [dpg_pkg::CharW-1:0] folded;
         folded = (c >= dpg_pkg::CHAR_UP_A && c <= dpg_pkg::CHAR_UP_Z) ?
                  c + dpg_pkg::CASE_GAP : c;
         if (c >= dpg_pkg::CHAR_ZERO && c <= dpg_pkg::CHAR_NINE) return dpg_pkg::UNIT_SEC;
         case (folded)
            dpg_pkg::CHAR_LO_S: return dpg_pkg::UNIT_SEC;
            dpg_pkg::CHAR_LO_M: return dpg_pkg::UNIT_MIN;
            dpg_pkg::CHAR_LO_H: return dpg_pkg::UNIT_HOUR;
            dpg_pkg::CHAR_LO_D: return dpg_pkg::UNIT_DAY;
            default:            return dpg_pkg::UNIT_BAD;
         endcase
      endfunction

      function logic [dpg_pkg::WordW-1:0] euclid(logic [dpg_pkg::WordW-1:0] a,
                                                 logic [dpg_pkg::WordW-1:0] b);
         logic [dpg_pkg::WordW-1:0] t;
         while (a != 0) begin
            t = a;
            a = b % a;
            b = t;
         end
         return b;
      endfunction

      function void note_char(logic [dpg_pkg::CharW-1:0] code, logic last, logic no_char);
         duration_result_type       r;
         logic [dpg_pkg::UnitW-1:0] scale;
         logic [63:0]               total;
         if (!last) begin
            if (!no_char) take_char(code);
            return;
         end
         r.status  = STATUS_REJECT;
         r.seconds = '0;
         if (!no_char) begin
            scale = scale_for(code);
            take_char(code);
            if (scale != dpg_pkg::UNIT_BAD && !overflow && !(negative && value != 0)) begin
               total = 64'(value) * 64'(scale);
               if (total <= 64'hffff_ffff) begin
                  r.status  = STATUS_OK;
                  r.seconds = total[dpg_pkg::WordW-1:0];
                  divisor   = euclid(divisor, r.seconds);
               end
            end
         end
         clear_parse();
         r.divisor = divisor;
         expected_q.push_back(r);
      endfunction

      function void compare(string field, logic [dpg_pkg::WordW-1:0] want,
                            logic [dpg_pkg::WordW-1:0] got);
         if (want !== got) begin
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic status, logic [dpg_pkg::WordW-1:0] seconds,
                                 logic [dpg_pkg::WordW-1:0] cd);
         duration_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t extra response: expected none, actual status %0d seconds %0d gcd %0d",
                     $time, status, seconds, cd);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare("rsp_status", 32'(want.status), 32'(status));
         compare("rsp_seconds", want.seconds, seconds);
         compare("rsp_common_divisor", want.divisor, cd);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [dpg_pkg::CharW-1:0] req_char_code = '0;
   logic                      req_is_last = 1'b0;
   logic                      req_no_char = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_status;
   logic [dpg_pkg::WordW-1:0] rsp_seconds;
   logic [dpg_pkg::WordW-1:0] rsp_common_divisor;

   gcd_scoreboard             sb;
   bit                        idle_on = 1'b1;
   int                        sent_count = 0;
   int                        quiet_cycles = 0;
   logic [dpg_pkg::CharW-1:0] text_q[$];

   string boundary_text[10] = '{"2147483647", "2147483648", "4294967295", "71582788m",
                                "71582789M", "1193046h", "1193047H", "49710d", "49711D",
                                "-00000000000000"};
   string unit_letters = "smhdSMHD";

   duration_parse_running_gcd_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_is_last        (req_is_last),
      .req_no_char        (req_no_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_seconds        (rsp_seconds),
      .rsp_common_divisor (rsp_common_divisor)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_status, rsp_seconds, rsp_common_divisor);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input logic [dpg_pkg::CharW-1:0] code, input logic last,
                            input logic no_char);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_is_last   <= last;
      req_no_char   <= no_char;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_char(code, last, no_char);
      // stray no_char transfers are ignored by the block
      if (last || !no_char) sent_count++;
   endtask

   // sends the queued characters as one string, with the odd stray no_char between them
   task automatic send_queued(input bit no_char_end);
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
         send_char(text_q[i], (i == n - 1) && !no_char_end, 1'b0);
      end
      if (no_char_end || n == 0) send_char(8'($urandom_range(255)), 1'b1, 1'b1);
      text_q.delete();
   endtask

   task automatic send_text(input string s, input bit no_char_end);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_queued(no_char_end);
   endtask

   function automatic logic [dpg_pkg::CharW-1:0] pick_space();
      int r;
      r = $urandom_range(6);
      return (r >= 5) ? dpg_pkg::CHAR_SPACE : dpg_pkg::CHAR_TAB + 8'(r);
   endfunction

   task automatic send_random_string();
      int kind;
      int ndig;
      int r;
      bit minus;
      kind = $urandom_range(99);
      if (kind < 3) begin
         send_queued(1'b0);
      end else if (kind < 8) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
         send_queued(1'b0);
      end else if (kind < 13) begin
         send_text(boundary_text[$urandom_range(9)], 1'b0);
      end else begin
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
         r     = $urandom_range(9);
         minus = (r == 0);
         if (minus) text_q.push_back(dpg_pkg::CHAR_MINUS);
         else if (r < 3) text_q.push_back(dpg_pkg::CHAR_PLUS);
         r = $urandom_range(99);
         if (r < 60) ndig = $urandom_range(1, 3);
         else if (r < 85) ndig = $urandom_range(4, 7);
         else ndig = $urandom_range(8, 11);
         // a minus sign only passes with an all-zero value
         if (minus && $urandom_range(1) == 0) begin
            repeat (ndig) text_q.push_back(dpg_pkg::CHAR_ZERO);
         end else begin
            repeat (ndig) text_q.push_back(dpg_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         end
         if ($urandom_range(19) == 0) begin
            text_q.insert($urandom_range(text_q.size() - 1), 8'($urandom_range(255)));
         end
         r = $urandom_range(99);
         if (r < 70) text_q.push_back(unit_letters[$urandom_range(7)]);
         else if (r >= 90) text_q.push_back(8'($urandom_range(255)));
         send_queued($urandom_range(99) < 3);
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty string, then the s, m and d units, both signs and rejection paths
      send_queued(1'b0);
      send_text("9", 1'b0);
      send_text("\t+6M", 1'b0);
      send_char(dpg_pkg::CHAR_MINUS, 1'b0, 1'b0);
      send_char(8'hff, 1'b0, 1'b1);
      send_char(dpg_pkg::CHAR_ZERO, 1'b0, 1'b0);
      send_char(dpg_pkg::CHAR_LO_D, 1'b1, 1'b0);
      send_text(" -5s", 1'b0);
      send_text("2", 1'b1);
      send_char(dpg_pkg::CHAR_ZERO + 8'd4, 1'b0, 1'b0);
      send_char(8'hff, 1'b1, 1'b0);
      send_char(8'h00, 1'b1, 1'b0);
      send_text("2147483648", 1'b0);
      send_text("49711d", 1'b0);

      while (sent_count < TARGET_CHARS) begin
         idle_on = !(sent_count >= 700 && sent_count < 1000);
         send_random_string();
      end
      idle_on = 1'b1;
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/dpg_pkg.sv
design/dpg_parser.sv
design/dpg_gcd.sv
design/duration_parse_running_gcd_core.sv
design/dpg_checker.sv
verif/duration_parse_running_gcd_core_test.sv
